### src/mhc_pkg.sv
// Shared widths, band constants, divider stage record and the color map.
// Depends on nothing; compiled first.
`default_nettype none

package mhc_pkg;

   localparam int MAG_W   = 16;           // magnitude and full scale
   localparam int LEVEL_W = 8;            // intensity 0..255
   localparam int NUM_W   = MAG_W + LEVEL_W;
   localparam int PIXEL_W = 16;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
   localparam logic [LEVEL_W-1:0] BAND1      = 8'd51;
   localparam logic [LEVEL_W-1:0] BAND2      = 8'd102;
   localparam logic [LEVEL_W-1:0] BAND3      = 8'd153;
   localparam logic [LEVEL_W-1:0] BAND4      = 8'd204;

   // One slot of the long-division pipeline.
   typedef struct packed {
      logic [NUM_W-1:0]   rem;   // partial remainder
      logic [MAG_W-1:0]   den;   // full scale
      logic [LEVEL_W-1:0] quo;   // quotient bits so far
      logic               sat;   // quotient would exceed 255
      logic               zero;  // black pixel
   } div_stage_type;

   // Intensity to RGB565. Ramp is 5 * offset within the band.
   function automatic logic [PIXEL_W-1:0] color_of(input logic [LEVEL_W-1:0] level);
      logic [LEVEL_W-1:0] start;
      logic [LEVEL_W-1:0] offs;
      logic [LEVEL_W-1:0] ramp;
      logic [LEVEL_W-1:0] r;
      logic [LEVEL_W-1:0] g;
      logic [LEVEL_W-1:0] b;
      if (level < BAND1)      start = '0;
      else if (level < BAND2) start = BAND1;
      else if (level < BAND3) start = BAND2;
      else if (level < BAND4) start = BAND3;
      else                    start = BAND4;
      offs = level - start;
      ramp = {offs[LEVEL_W-3:0], 2'b00} + offs;
      if (level < BAND1) begin
         r = '0;         g = '0;                  b = ramp;
      end else if (level < BAND2) begin
         r = '0;         g = ramp;                b = FULL_LEVEL;
      end else if (level < BAND3) begin
         r = '0;         g = FULL_LEVEL;          b = FULL_LEVEL - ramp;
      end else if (level < BAND4) begin
         r = ramp;       g = FULL_LEVEL;          b = '0;
      end else begin
         r = FULL_LEVEL; g = FULL_LEVEL - ramp;   b = '0;
      end
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

`default_nettype wire

### src/mhc_channels.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on mhc_pkg for field widths.
`default_nettype none

interface mhc_req_if import mhc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic [MAG_W-1:0] full_scale;

   modport source (output valid, output magnitude, output full_scale, input ready);
   modport sink   (input valid, input magnitude, input full_scale, output ready);
endinterface

interface mhc_rsp_if import mhc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_color;

   modport source (output valid, output pixel_color, input ready);
   modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

### src/magnitude_heatmap_color.sv
// A transaction accepted on req_chan passes the prep stage, eight one-bit divider
//   stages and the color/output register before its pixel shows on rsp_chan.
// Throughput: one per clock unless rsp_chan stalls; up to nine sit in the divider.
// Stalls on rsp_chan back up stage by stage; empty stages keep taking new work.
// Reset (synchronous, active high) clears all valid bits; no payload is reset.
//
// Top level: magnitude to RGB565 heatmap pixel.
// Depends on mhc_pkg, mhc_channels (interfaces) and mhc_divider.
`default_nettype none

module magnitude_heatmap_color import mhc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mhc_req_if.sink   req_chan,
   mhc_rsp_if.source rsp_chan
);

   logic               div_valid;
   logic               div_ready;
   logic [LEVEL_W-1:0] div_level;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [PIXEL_W-1:0] pixel_ff;
   logic [PIXEL_W-1:0] pixel_in;

   // Intensity = min(255, magnitude*255/full_scale); zero input gives level 0,
   // which the color map renders as black.
   mhc_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .magnitude  (req_chan.magnitude),
      .full_scale (req_chan.full_scale),
      .out_valid  (div_valid),
      .out_ready  (div_ready),
      .out_level  (div_level)
   );

   // Output register: free when empty or being taken this cycle.
   assign div_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = div_ready ? div_valid : rsp_valid_ff;
   assign pixel_in     = color_of(div_level);   // band select, 5x ramp, 565 pack

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready && div_valid) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_color = pixel_ff;

endmodule

`default_nettype wire

### src/mhc_divider.sv
// Pipelined restoring divider: level = min(255, magnitude*255 / full_scale).
// One quotient bit per stage, elastic valid/ready. Depends on mhc_pkg.
`default_nettype none

module mhc_divider import mhc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire logic [MAG_W-1:0]   magnitude,
   input  wire logic [MAG_W-1:0]   full_scale,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      logic [LEVEL_W-1:0] out_level
);

   localparam int STEPS = LEVEL_W;
   localparam int NST   = STEPS + 1;   // prep stage + one stage per bit

   div_stage_type        st_ff [NST];
   div_stage_type        st_in [NST];
   logic [NST-1:0]       v_ff;
   logic [NST-1:0]       v_in;
   logic [NST-1:0]       load;

   // Stage loads when empty or when its content moves on (bubbles squeeze out).
   always_comb begin
      load[NST-1] = !v_ff[NST-1] || out_ready;
      for (int i = NST-2; i >= 0; i--) begin
         load[i] = !v_ff[i] || load[i+1];
      end
   end

   assign in_ready = load[0];
   assign v_in     = {v_ff[NST-2:0], in_valid};

   // Prep: numerator = magnitude * 255 as a shift and subtract.
   always_comb begin
      st_in[0].rem  = {magnitude, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, magnitude};
      st_in[0].den  = full_scale;
      st_in[0].quo  = '0;
      st_in[0].sat  = 1'b0;
      st_in[0].zero = (magnitude == '0) || (full_scale == '0);
   end

   for (genvar s = 1; s < NST; s++) begin : g_step
      localparam int BIT = STEPS - s;
      logic [NUM_W-1:0] shifted;
      logic             fits;
      assign shifted = {{LEVEL_W{1'b0}}, st_ff[s-1].den} << BIT;
      assign fits    = st_ff[s-1].rem >= shifted;
      always_comb begin
         st_in[s]     = st_ff[s-1];
         if (s == 1) begin
            st_in[s].sat = st_ff[s-1].rem >= {st_ff[s-1].den, {LEVEL_W{1'b0}}};
         end
         if (fits) begin
            st_in[s].rem = st_ff[s-1].rem - shifted;
         end
         st_in[s].quo[BIT] = fits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (load[i]) v_ff[i] <= v_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NST; i++) begin
         if (load[i]) st_ff[i] <= st_in[i];
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_level = st_ff[NST-1].zero ? '0 :
                      st_ff[NST-1].sat  ? FULL_LEVEL : st_ff[NST-1].quo;

   // Remainder stays below the shifted divisor once each bit is settled.
   for (genvar s = 1; s < NST; s++) begin : g_chk
      localparam int BIT = STEPS - s;
      assert property (@(posedge clock) disable iff (reset)
         v_ff[s] && !st_ff[s].sat && !st_ff[s].zero |->
            st_ff[s].rem < ({{LEVEL_W{1'b0}}, st_ff[s].den} << BIT))
         else $error("divider remainder out of range");
   end

   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v_ff[0])
      else $error("accepted transaction not captured");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] && !out_ready |=> v_ff[NST-1] && $stable(out_level))
      else $error("stalled divider result lost");

endmodule

`default_nettype wire

### test/magnitude_heatmap_color_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for magnitude_heatmap_color: drives magnitude/full-scale
// transactions and checks every RGB565 pixel against an in-bench color predictor.
// Depends on mhc_pkg, mhc_channels and the magnitude_heatmap_color RTL.

module magnitude_heatmap_color_test;
   import mhc_pkg::*;

   localparam int CLOCK_HALF   = 2;       // 4 ns period
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 20;      // margin after the last expected pixel arrives
   localparam int CYCLE_LIMIT  = 200000;  // 825 transactions in all, with ample margin
   localparam int MAX_REPORTS  = 10;
   localparam int RAMP_STEP    = 5;       // (x * 255) / 51 per band

   logic clock;
   logic reset;

   mhc_req_if req_chan ();
   mhc_rsp_if rsp_chan ();

   magnitude_heatmap_color i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Pixels expected back, oldest first. Filled at request handshake,
   // drained at response handshake.
   logic [PIXEL_W-1:0] expected_pixels[$];

   int send_idle_pct  = 0;   // chance per cycle that the sender holds off
   int recv_stall_pct = 0;   // chance per cycle that the receiver drops ready
   int error_count    = 0;
   int sent_count     = 0;
   int pixel_count    = 0;
   int cycle_count    = 0;

   // ------------------------------------------------------------------
   // Clock, cycle limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels still outstanding",
                  cycle_count, expected_pixels.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Color predictor. Intensity is magnitude*255/full_scale, clamped to
   // 255; black when either input is zero. Five bands of 51 steps each
   // walk black -> blue -> cyan -> green -> yellow -> red, ramp is
   // 5 * offset into the band. Channels truncated to 5/6/5 bits.
   // ------------------------------------------------------------------
   function automatic logic [PIXEL_W-1:0] heatmap_pixel(input logic [MAG_W-1:0] magnitude,
                                                        input logic [MAG_W-1:0] full_scale);
      logic [31:0] scaled;
      logic [31:0] level;
      logic [31:0] ramp;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      if (magnitude == '0 || full_scale == '0)
         return '0;
      scaled = 32'(magnitude) * 32'(FULL_LEVEL);
      level  = scaled / 32'(full_scale);
      if (level > 32'(FULL_LEVEL))
         level = 32'(FULL_LEVEL);
      if (level < 32'(BAND1)) begin
         ramp = level * RAMP_STEP;
         red = 8'd0;        green = 8'd0;             blue = ramp[7:0];
      end else if (level < 32'(BAND2)) begin
         ramp = (level - 32'(BAND1)) * RAMP_STEP;
         red = 8'd0;        green = ramp[7:0];        blue = FULL_LEVEL;
      end else if (level < 32'(BAND3)) begin
         ramp = (level - 32'(BAND2)) * RAMP_STEP;
         red = 8'd0;        green = FULL_LEVEL;       blue = FULL_LEVEL - ramp[7:0];
      end else if (level < 32'(BAND4)) begin
         ramp = (level - 32'(BAND3)) * RAMP_STEP;
         red = ramp[7:0];   green = FULL_LEVEL;       blue = 8'd0;
      end else begin
         ramp = (level - 32'(BAND4)) * RAMP_STEP;
         red = FULL_LEVEL;  green = FULL_LEVEL - ramp[7:0]; blue = 8'd0;
      end
      return {red[7:3], green[7:2], blue[7:3]};
   endfunction

   task automatic note_failure(input string what, input logic [PIXEL_W-1:0] expected,
                               input logic [PIXEL_W-1:0] actual);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR cycle %0d: %s expected pixel_color 0x%04h, got 0x%04h",
                  cycle_count, what, expected, actual);
   endtask

   // ------------------------------------------------------------------
   // Response side: compare each accepted pixel with the oldest
   // expectation, then pick ready for the next cycle. Values read here
   // are the ones present just before the edge.
   // ------------------------------------------------------------------
   initial begin
      logic [PIXEL_W-1:0] expected;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            pixel_count++;
            if (expected_pixels.size() == 0) begin
               note_failure("unexpected transaction,", '0, rsp_chan.pixel_color);
            end else begin
               expected = expected_pixels.pop_front();
               if (rsp_chan.pixel_color !== expected)
                  note_failure("mismatch,", expected, rsp_chan.pixel_color);
            end
         end
         rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Request side. Valid stays high from one transaction to the next
   // unless an idle gap is drawn; the expectation is queued at the edge
   // where the handshake happens.
   // ------------------------------------------------------------------
   task automatic send_sample(input logic [MAG_W-1:0] magnitude,
                              input logic [MAG_W-1:0] full_scale);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.magnitude  <= magnitude;
      req_chan.full_scale <= full_scale;
      do @(posedge clock); while (!req_chan.ready);
      expected_pixels.push_back(heatmap_pixel(magnitude, full_scale));
      sent_count++;
   endtask

   // Either input zero gives black; a tiny nonzero intensity also rounds to black.
   task automatic test_zero_inputs();
      send_sample(16'h0000, 16'hFFFF);
      send_sample(16'hFFFF, 16'h0000);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h0001, 16'hFFFF);
   endtask

   // Full scale of 255 makes intensity equal to magnitude, so each band
   // edge can be hit exactly, including the top of the last band.
   task automatic test_band_boundaries();
      int levels[16] = '{1, 2, 50, 51, 52, 101, 102, 103,
                         152, 153, 154, 203, 204, 205, 254, 255};
      foreach (levels[i])
         send_sample(16'(levels[i]), 16'(FULL_LEVEL));
   endtask

   // Magnitude at or above full scale clamps to red; 0x5555/0xAAAA lands mid-range.
   task automatic test_saturation();
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 16'h0001);
      send_sample(16'h0100, 16'h00FF);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'h5555, 16'hAAAA);
   endtask

   // Random mix: most transactions aim at a random intensity so that all
   // bands are well populated, the rest are uniform words and zero inputs.
   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      logic [MAG_W-1:0] magnitude;
      logic [MAG_W-1:0] full_scale;
      int unsigned      target;
      int unsigned      kind;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         kind = $urandom_range(9);
         if (kind == 0) begin
            magnitude  = $urandom_range(1) ? 16'h0000 : 16'($urandom);
            full_scale = (magnitude == '0 && $urandom_range(1)) ? 16'($urandom) : 16'h0000;
         end else if (kind <= 2) begin
            magnitude  = 16'($urandom);
            full_scale = 16'($urandom);
         end else begin
            full_scale = 16'($urandom_range(65535, 1));
            target     = (int'(full_scale) * $urandom_range(255)) / 255
                         + $urandom_range(3);
            magnitude  = (target > 65535) ? 16'hFFFF : 16'(target);
         end
         send_sample(magnitude, full_scale);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.magnitude  <= '0;
      req_chan.full_scale <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_inputs();
      test_band_boundaries();
      test_saturation();

      // Idle phases: none, sender gaps, receiver stalls, both.
      test_random_mix(200, 0, 0);
      test_random_mix(200, 68, 0);
      test_random_mix(200, 0, 68);
      test_random_mix(200, 37, 37);

      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (zero inputs, band edges, clamping, random mix)",
               sent_count);
      $display("Checked %0d pixels under four sender/receiver idle patterns, %0d errors",
               pixel_count, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
